// ===== hw/rtl/ssq_pkg.sv =====
`default_nettype none

package ssq_pkg;

  // Field widths of the stream payloads.
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned PULSE_W    = 16;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned SERVO_W    = 4;
  localparam int unsigned END_W      = 2;
  localparam int unsigned DWELL_W    = 16;

  // Packed stream widths; the tdata widths are rounded up to whole bytes.
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 4;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_INDEX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_END_PULSE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TIME  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT  = 3'd5;

  // Register reset values and the defaults that replace zero settings.
  localparam logic [PULSE_W-1:0] RST_START_PULSE = 16'd1500;
  localparam logic [PULSE_W-1:0] RST_END_PULSE   = 16'd1500;
  localparam logic [PULSE_W-1:0] DEF_STEP        = 16'd10;
  localparam logic [DWELL_W-1:0] DEF_DWELL       = 16'd300;
  localparam logic [ANGLE_W-1:0] DEF_LIMIT       = 16'd2048;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_START = 2'd0,
    FUNC_STOP  = 2'd1,
    FUNC_TICK  = 2'd2
  } ssq_func_t;

  typedef enum logic [END_W-1:0] {
    END_NONE = 2'd0,
    END_TILT = 2'd1,
    END_DONE = 2'd2
  } ssq_end_t;

  // Resolved settings, with zero and non-positive values already defaulted.
  typedef struct packed {
    logic [SERVO_W-1:0] servo_index;
    logic [PULSE_W-1:0] start_pulse;
    logic [PULSE_W-1:0] end_pulse;
    logic [PULSE_W-1:0] step;
    logic [DWELL_W-1:0] dwell;
    logic [ANGLE_W-1:0] limit;
  } ssq_cfg_t;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [TIME_W-1:0]         now_ms;
    logic                      imu_ok;
    logic signed [ANGLE_W-1:0] pitch;
    logic signed [ANGLE_W-1:0] roll;
  } ssq_item_t;

  typedef struct packed {
    logic                      point_valid;
    logic [PULSE_W-1:0]        point_pulse;
    logic signed [ANGLE_W-1:0] report_pitch;
    logic signed [ANGLE_W-1:0] report_roll;
    logic [END_W-1:0]          end_code;
    logic                      go_standing;
    logic                      drive_valid;
    logic [SERVO_W-1:0]        drive_servo;
    logic [PULSE_W-1:0]        drive_pulse;
    logic                      running;
  } ssq_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/servo_sweep_sequencer.sv =====
`default_nettype none

// Servo sweep sequencer. Each transfer on the input stream carries one command
// (start, stop or a time tick with a tilt reading) and produces exactly one
// transfer on the output stream, in order. A command is taken into an input
// register, the sweep logic evaluates it against the stored sweep state, and
// the result lands in an output register. The block accepts one command per
// cycle while the output side takes its results; that rate is set by the update
// of the sweep state (current pulse, step time and the run flag), which each
// command reads and writes. The user must write settings through the cfg port
// only while no command is in flight; the block itself does not enforce this.
// Settings are used as they stand for every command.
module servo_sweep_sequencer #(
  parameter int unsigned SERVO_COUNT = 8
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Configuration writes.
  input  wire                                  cfg_wr_en,
  input  wire  [ssq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [ssq_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // Command stream.
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // tdata from bit 0: now_ms[31:0], imu_ok[32], pitch[48:33], roll[64:49], zero pad.
  input  wire  [ssq_pkg::IN_TDATA_W-1:0]       in_tdata,
  // tuser from bit 0: func[1:0].
  input  wire  [ssq_pkg::IN_TUSER_W-1:0]       in_tuser,
  // Result stream.
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // tdata from bit 0: point_pulse[15:0], report_pitch[31:16], report_roll[47:32],
  // go_standing[48], drive_servo[52:49], drive_pulse[68:53], running[69], zero pad.
  output logic [ssq_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // tuser from bit 0: point_valid[0], end_code[2:1], drive_valid[3].
  output logic [ssq_pkg::OUT_TUSER_W-1:0]      out_tuser
);
  import ssq_pkg::*;

  ssq_cfg_t    cfg;
  ssq_item_t   item_r;
  logic        item_valid_r, item_valid_nxt;
  logic        item_adv;
  logic        in_xfer;
  ssq_result_t result;
  ssq_result_t result_r;
  logic        out_valid_r, out_valid_nxt;

  ssq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ssq_core #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_adv (item_adv),
    .item     (item_r),
    .result   (result)
  );

  // Handshake: the input register refills whenever its item moves on.
  assign item_adv  = item_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !item_valid_r || item_adv;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    item_valid_nxt = item_valid_r;
    if (in_xfer) begin
      item_valid_nxt = 1'b1;
    end else if (item_adv) begin
      item_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (item_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.func   <= in_tuser[FUNC_W-1:0];
      item_r.now_ms <= in_tdata[31:0];
      item_r.imu_ok <= in_tdata[32];
      item_r.pitch  <= in_tdata[48:33];
      item_r.roll   <= in_tdata[64:49];
    end
    if (item_adv) begin
      result_r <= result;
    end
  end

  // Output packing.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       result_r.running,
                       result_r.drive_pulse,
                       result_r.drive_servo,
                       result_r.go_standing,
                       result_r.report_roll,
                       result_r.report_pitch,
                       result_r.point_pulse};
  assign out_tuser  = {result_r.drive_valid, result_r.end_code, result_r.point_valid};

endmodule

`default_nettype wire

// ===== hw/rtl/ssq_cfg_regs.sv =====
`default_nettype none

module ssq_cfg_regs (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_wr_en,
  input  wire  [ssq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [ssq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output ssq_pkg::ssq_cfg_t                   cfg
);
  import ssq_pkg::*;

  logic [SERVO_W-1:0] servo_index_r;
  logic [PULSE_W-1:0] start_pulse_r;
  logic [PULSE_W-1:0] end_pulse_r;
  logic [PULSE_W-1:0] pulse_step_r;
  logic [DWELL_W-1:0] dwell_time_r;
  logic [ANGLE_W-1:0] tilt_limit_r;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_index_r <= '0;
      start_pulse_r <= RST_START_PULSE;
      end_pulse_r   <= RST_END_PULSE;
      pulse_step_r  <= DEF_STEP;
      dwell_time_r  <= DEF_DWELL;
      tilt_limit_r  <= DEF_LIMIT;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SERVO_INDEX: servo_index_r <= cfg_wdata[SERVO_W-1:0];
        CFG_START_PULSE: start_pulse_r <= cfg_wdata[PULSE_W-1:0];
        CFG_END_PULSE:   end_pulse_r   <= cfg_wdata[PULSE_W-1:0];
        CFG_PULSE_STEP:  pulse_step_r  <= cfg_wdata[PULSE_W-1:0];
        CFG_DWELL_TIME:  dwell_time_r  <= cfg_wdata[DWELL_W-1:0];
        CFG_TILT_LIMIT:  tilt_limit_r  <= cfg_wdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero step, zero dwell and a non-positive limit fall back to defaults.
  always_comb begin
    cfg.servo_index = servo_index_r;
    cfg.start_pulse = start_pulse_r;
    cfg.end_pulse   = end_pulse_r;
    cfg.step        = (pulse_step_r == '0) ? DEF_STEP : pulse_step_r;
    cfg.dwell       = (dwell_time_r == '0) ? DEF_DWELL : dwell_time_r;
    cfg.limit       = (tilt_limit_r[ANGLE_W-1] || tilt_limit_r == '0) ?
                      DEF_LIMIT : tilt_limit_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssq_core.sv =====
`default_nettype none

module ssq_core #(
  parameter int unsigned SERVO_COUNT = 8
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire ssq_pkg::ssq_cfg_t  cfg,
  input  wire                   item_adv,
  input  wire ssq_pkg::ssq_item_t item,
  output ssq_pkg::ssq_result_t  result
);
  import ssq_pkg::*;

  logic               sweep_on_r,   sweep_on_nxt;
  logic [PULSE_W-1:0] step_pulse_r, step_pulse_nxt;
  logic [TIME_W-1:0]  step_time_r,  step_time_nxt;

  logic               servo_ok;
  logic [TIME_W-1:0]  elapsed;
  logic               dwell_done;
  logic [ANGLE_W:0]   pitch_mag;
  logic [ANGLE_W:0]   roll_mag;
  logic               tilt_over;
  logic               sweep_up;
  logic [PULSE_W:0]   pulse_sum;
  logic [PULSE_W-1:0] pulse_next;
  logic               pass_end;

  assign servo_ok   = {1'b0, cfg.servo_index} < (SERVO_W+1)'(SERVO_COUNT);
  assign elapsed    = item.now_ms - step_time_r;
  assign dwell_done = elapsed >= {{(TIME_W-DWELL_W){1'b0}}, cfg.dwell};

  // Tilt magnitudes keep one extra bit so the most negative reading fits.
  assign pitch_mag = item.pitch[ANGLE_W-1] ?
                     ((ANGLE_W+1)'(0) - {item.pitch[ANGLE_W-1], item.pitch}) :
                     {1'b0, item.pitch};
  assign roll_mag  = item.roll[ANGLE_W-1] ?
                     ((ANGLE_W+1)'(0) - {item.roll[ANGLE_W-1], item.roll}) :
                     {1'b0, item.roll};
  assign tilt_over = (pitch_mag > {1'b0, cfg.limit}) || (roll_mag > {1'b0, cfg.limit});

  // Next sweep point, wrapping at 16 bits, and the end-of-sweep test.
  assign sweep_up   = cfg.start_pulse <= cfg.end_pulse;
  assign pulse_sum  = sweep_up ? ({1'b0, step_pulse_r} + {1'b0, cfg.step}) :
                                 ({1'b0, step_pulse_r} - {1'b0, cfg.step});
  assign pulse_next = pulse_sum[PULSE_W-1:0];
  assign pass_end   = sweep_up ? (pulse_next > cfg.end_pulse) :
                                 (pulse_next < cfg.end_pulse);

  // Result and state update for the item in the input register.
  always_comb begin
    sweep_on_nxt   = sweep_on_r;
    step_pulse_nxt = step_pulse_r;
    step_time_nxt  = step_time_r;
    result         = '0;

    case (item.func)
      FUNC_START: begin
        if (servo_ok) begin
          result.go_standing = 1'b1;
          result.drive_valid = 1'b1;
          result.drive_servo = cfg.servo_index;
          result.drive_pulse = cfg.start_pulse;
          step_pulse_nxt     = cfg.start_pulse;
          step_time_nxt      = item.now_ms;
          sweep_on_nxt       = 1'b1;
        end
      end
      FUNC_STOP: begin
        if (sweep_on_r) begin
          result.go_standing = 1'b1;
          sweep_on_nxt       = 1'b0;
        end
      end
      FUNC_TICK: begin
        if (sweep_on_r && dwell_done) begin
          if (item.imu_ok) begin
            result.report_pitch = item.pitch;
            result.report_roll  = item.roll;
          end
          if (item.imu_ok && tilt_over) begin
            result.end_code    = END_TILT;
            result.go_standing = 1'b1;
            sweep_on_nxt       = 1'b0;
          end else begin
            result.point_valid = item.imu_ok;
            result.point_pulse = item.imu_ok ? step_pulse_r : '0;
            step_pulse_nxt     = pulse_next;
            if (pass_end) begin
              result.end_code    = END_DONE;
              result.go_standing = 1'b1;
              sweep_on_nxt       = 1'b0;
            end else begin
              result.drive_valid = 1'b1;
              result.drive_servo = cfg.servo_index;
              result.drive_pulse = pulse_next;
              step_time_nxt      = item.now_ms;
            end
          end
        end
      end
      default: ;
    endcase

    result.running = sweep_on_nxt;
  end

  // Sweep state advances once for each item that moves to the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_on_r   <= 1'b0;
      step_pulse_r <= '0;
      step_time_r  <= '0;
    end else if (item_adv) begin
      sweep_on_r   <= sweep_on_nxt;
      step_pulse_r <= step_pulse_nxt;
      step_time_r  <= step_time_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ssq_checker.sv =====
`default_nettype none

module ssq_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               out_tvalid,
  input wire                               out_tready,
  input wire [ssq_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input wire [ssq_pkg::OUT_TUSER_W-1:0]    out_tuser
);
  import ssq_pkg::*;

  // A held result keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A new drive is only issued while the sweep keeps running.
  a_drive_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tdata[69])
    else $error("drive issued with sweep stopped");

  // Any end of sweep stops the run and sends the servos to standing.
  a_end_standing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] != END_NONE) |-> out_tdata[48] && !out_tdata[69])
    else $error("sweep ended without standing request");

  // A tilt abort never also reports a point or a drive.
  a_abort_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[2:1] == END_TILT) |-> !out_tuser[0] && !out_tuser[3])
    else $error("tilt abort mixed with point or drive");

  // No result is offered right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind servo_sweep_sequencer ssq_checker u_ssq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
